/* src/pn3_pkg.sv */
package pn3_pkg;

    localparam int FRACTION_BITS_DEF = 32;
    localparam int WORK_BITS         = 24;
    localparam int WRAP_BITS         = 25;
    localparam int PERM_AW           = 8;
    localparam int PERM_DEPTH        = 1 << PERM_AW;
    localparam int LERP_W            = 30;
    localparam int FADE_W            = 26;
    localparam int DOT_W             = 27;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    localparam logic [1:0] CFG_OFFSET_X = 2'd0;
    localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
    localparam logic [1:0] CFG_OFFSET_Z = 2'd2;
    localparam logic [1:0] CFG_WRAP     = 2'd3;

    // gradient components {gx, gy, gz}, each 2-bit two's complement
    localparam logic [5:0] GRAD [16] = '{
        6'b01_01_00, 6'b11_01_00, 6'b01_11_00, 6'b11_11_00,
        6'b01_00_01, 6'b11_00_01, 6'b01_00_11, 6'b11_00_11,
        6'b00_01_01, 6'b00_11_01, 6'b00_01_11, 6'b00_11_11,
        6'b01_01_00, 6'b00_11_01, 6'b11_01_00, 6'b00_11_11
    };

    typedef logic [PERM_AW-1:0]         byte_t;
    typedef logic [WORK_BITS-1:0]       frac_t;
    typedef logic signed [DOT_W-1:0]    dot_t;
    typedef logic signed [LERP_W-1:0]   lerp_t;
    typedef logic signed [FADE_W-1:0]   fade_t;

    typedef struct packed {
        logic  we;
        byte_t waddr;
        byte_t wdata;
    } perm_wr_t;

endpackage

/* src/pn3_perm_ram.sv */
module pn3_perm_ram (
    input  logic              aclk,
    input  logic              en,
    input  pn3_pkg::perm_wr_t wr,
    input  pn3_pkg::byte_t    raddr0,
    input  pn3_pkg::byte_t    raddr1,
    output pn3_pkg::byte_t    rdata0,
    output pn3_pkg::byte_t    rdata1
);
    import pn3_pkg::*;

    byte_t mem [PERM_DEPTH];
    byte_t rdata0_reg;
    byte_t rdata1_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.waddr] <= wr.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

/* src/pn3_axis.sv */
module pn3_axis #(
    parameter int FRACTION_BITS = pn3_pkg::FRACTION_BITS_DEF
) (
    input  logic           aclk,
    input  logic           en,
    input  logic           wrap,
    input  logic [63:0]    coord,
    input  logic [63:0]    offset,
    output logic [31:0]    cell_idx,
    output pn3_pkg::frac_t frac
);
    import pn3_pkg::*;

    localparam int WB = WRAP_BITS + FRACTION_BITS;
    localparam int FW = FRACTION_BITS + WORK_BITS;

    logic [63:0]   wrapped;
    logic [63:0]   sum_next;
    logic [63:0]   sum_reg;
    logic          ovf_reg;
    logic          neg_reg;
    logic          fits;
    logic [FW-1:0] fext;

    assign wrapped  = wrap ? {{(64-WB){coord[WB-1]}}, coord[WB-1:0]} : coord;
    assign sum_next = wrapped + offset;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
            ovf_reg <= (wrapped[63] == offset[63]) && (sum_next[63] != wrapped[63]);
            neg_reg <= wrapped[63];
        end
    end

    assign fits = (&sum_reg[63:FRACTION_BITS+31]) | ~(|sum_reg[63:FRACTION_BITS+31]);
    assign fext = {sum_reg[FRACTION_BITS-1:0], {WORK_BITS{1'b0}}} >> FRACTION_BITS;

    always_comb begin
        if (ovf_reg) begin
            cell_idx = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            frac     = neg_reg ? '0 : '1;
        end else if (!fits) begin
            cell_idx = sum_reg[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            frac     = sum_reg[63] ? '0 : '1;
        end else begin
            cell_idx = sum_reg[FRACTION_BITS+31:FRACTION_BITS];
            frac     = fext[WORK_BITS-1:0];
        end
    end

endmodule

/* src/pn3_skid.sv */
module pn3_skid #(
    parameter int W = 27
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic [W-1:0] out_data_reg;
    logic [W-1:0] skid_data_reg;
    logic         in_fire;
    logic         drain;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign drain    = out_ready || !out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (drain) begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* src/perlin_noise_3d_eval.sv */
// 3D improved Perlin noise evaluator, ten register stages plus an output skid stage.
// An accepted point passes the ten register stages and the skid register to m_tvalid.
// Throughput: one beat per unstalled cycle, loads and points alike; table reads use seven
// dual-read copies of the permutation table, each written as a load passes its stage.
// Reset clears valid bits, the written-entry flags and the offset and wrap registers;
// the table contents stay undefined until loaded, and points are dropped until all 256 are.
module perlin_noise_3d_eval #(
    parameter int FRACTION_BITS = pn3_pkg::FRACTION_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [207:0] s_tdata,   // perm_index, perm_value, coord_x, coord_y, coord_z
    input  logic         s_tuser,   // kind
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // noise_value, zero fill
    output logic         m_tlast
);
    import pn3_pkg::*;

    function automatic logic signed [24:0] corner(input frac_t f, input logic o);
        corner = o ? {1'b1, f} : {1'b0, f};
    endfunction

    function automatic dot_t gterm(input logic [1:0] g, input logic signed [24:0] v);
        case (g)
            2'b01:   gterm = dot_t'(v);
            2'b11:   gterm = -dot_t'(v);
            default: gterm = '0;
        endcase
    endfunction

    function automatic dot_t gdot(input logic [3:0] h, input logic signed [24:0] x,
                                  input logic signed [24:0] y, input logic signed [24:0] z);
        logic [5:0] g;
        g = GRAD[h];
        gdot = gterm(g[5:4], x) + gterm(g[3:2], y) + gterm(g[1:0], z);
    endfunction

    function automatic logic signed [56:0] lerp_prod(input fade_t u, input lerp_t a,
                                                     input lerp_t b);
        logic signed [LERP_W:0] diff;
        logic signed [56:0]     p;
        diff = (LERP_W+1)'(b) - (LERP_W+1)'(a);
        p = u * diff;
        lerp_prod = p;
    endfunction

    function automatic lerp_t lerp_fin(input lerp_t a, input logic signed [56:0] p);
        logic signed [56:0] sh;
        sh = p >>> WORK_BITS;
        lerp_fin = lerp_t'(a + sh[LERP_W-1:0]);
    endfunction

    // configuration
    logic [63:0] off_reg [3];
    logic        wrap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                off_reg[i] <= '0;
            end
            wrap_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OFFSET_X: off_reg[0] <= cfg_data;
                CFG_OFFSET_Y: off_reg[1] <= cfg_data;
                CFG_OFFSET_Z: off_reg[2] <= cfg_data;
                CFG_WRAP:     wrap_reg   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // input beat and written-entry tracking
    logic        adv;
    logic        s_fire;
    logic        skid_ready;
    byte_t       in_idx;
    byte_t       in_val;
    logic [63:0] coord [3];
    logic [PERM_DEPTH-1:0] written_reg;
    logic [PERM_AW:0]      count_reg;
    logic        full;

    assign adv      = skid_ready;
    assign s_tready = adv;
    assign s_fire   = s_tvalid && adv;
    assign in_idx   = s_tdata[7:0];
    assign in_val   = s_tdata[15:8];
    assign coord[0] = s_tdata[79:16];
    assign coord[1] = s_tdata[143:80];
    assign coord[2] = s_tdata[207:144];
    assign full     = count_reg[PERM_AW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            count_reg   <= '0;
        end else if (s_fire && s_tuser == KIND_LOAD && !written_reg[in_idx]) begin
            written_reg[in_idx] <= 1'b1;
            count_reg           <= count_reg + 1'b1;
        end
    end

    // stage 1: wrapped and offset sums inside the axis units
    logic [31:0] cell_idx [3];
    frac_t       fr1 [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        pn3_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis (
            .aclk     (aclk),
            .en       (adv),
            .wrap     (wrap_reg),
            .coord    (coord[a]),
            .offset   (off_reg[a]),
            .cell_idx (cell_idx[a]),
            .frac     (fr1[a])
        );
    end

    logic  pt1_reg, ld1_reg, last1_reg;
    byte_t idx1_reg, val1_reg;

    // stage 2..10 registers
    logic  pt2_reg, ld2_reg, last2_reg;
    byte_t idx2_reg, val2_reg, cy2_reg, cz2_reg;
    frac_t fr2_reg [3];

    logic  pt3_reg, ld3_reg, last3_reg;
    byte_t idx3_reg, val3_reg, cz3_reg;
    frac_t fr3_reg [3];
    frac_t tt3_reg [3];
    logic signed [29:0] in3_reg [3];

    logic  pt4_reg, last4_reg;
    frac_t fr4_reg [3];
    frac_t cube4_reg [3];
    logic signed [29:0] in4_reg [3];

    logic  pt5_reg, last5_reg;
    dot_t  d5_reg [8];
    fade_t u5_reg [3];

    logic  pt6_reg, last6_reg;
    lerp_t a6_reg [4];
    logic signed [56:0] p6_reg [4];
    fade_t uy6_reg, uz6_reg;

    logic  pt7_reg, last7_reg;
    lerp_t lx7_reg [4];
    fade_t uy7_reg, uz7_reg;

    logic  pt8_reg, last8_reg;
    lerp_t a8_reg [2];
    logic signed [56:0] p8_reg [2];
    fade_t uz8_reg;

    logic  pt9_reg, last9_reg;
    lerp_t ly9_reg [2];
    fade_t uz9_reg;

    logic  pt10_reg, last10_reg;
    lerp_t a10_reg;
    logic signed [56:0] p10_reg;

    // table copies: A at stage 1, B at stage 2, C at stage 3
    byte_t    ra0, ra1;
    byte_t    a_hash [2];
    byte_t    b_rd0 [2];
    byte_t    b_rd1 [2];
    byte_t    c_base [4];
    byte_t    c_rd0 [4];
    byte_t    c_rd1 [4];
    perm_wr_t wr_a, wr_b, wr_c;

    assign wr_a = '{we: adv && ld1_reg, waddr: idx1_reg, wdata: val1_reg};
    assign wr_b = '{we: adv && ld2_reg, waddr: idx2_reg, wdata: val2_reg};
    assign wr_c = '{we: adv && ld3_reg, waddr: idx3_reg, wdata: val3_reg};

    pn3_perm_ram u_ram_a (
        .aclk   (aclk),
        .en     (adv),
        .wr     (wr_a),
        .raddr0 (cell_idx[0][7:0]),
        .raddr1 (cell_idx[0][7:0] + 8'd1),
        .rdata0 (ra0),
        .rdata1 (ra1)
    );

    assign a_hash[0] = ra0;
    assign a_hash[1] = ra1;

    for (genvar k = 0; k < 2; k++) begin : g_ram_b
        pn3_perm_ram u_ram_b (
            .aclk   (aclk),
            .en     (adv),
            .wr     (wr_b),
            .raddr0 (a_hash[k] + cy2_reg),
            .raddr1 (a_hash[k] + cy2_reg + 8'd1),
            .rdata0 (b_rd0[k]),
            .rdata1 (b_rd1[k])
        );
    end

    assign c_base[0] = b_rd0[0];
    assign c_base[1] = b_rd0[1];
    assign c_base[2] = b_rd1[0];
    assign c_base[3] = b_rd1[1];

    for (genvar k = 0; k < 4; k++) begin : g_ram_c
        pn3_perm_ram u_ram_c (
            .aclk   (aclk),
            .en     (adv),
            .wr     (wr_c),
            .raddr0 (c_base[k] + cz3_reg),
            .raddr1 (c_base[k] + cz3_reg + 8'd1),
            .rdata0 (c_rd0[k]),
            .rdata1 (c_rd1[k])
        );
    end

    // fade pieces and corner gradient dot products
    frac_t              tt_next [3];
    logic signed [29:0] in_next [3];
    frac_t              cube_next [3];
    fade_t              u_next [3];
    dot_t               d_next [8];

    always_comb begin
        logic [47:0]        sq;
        logic [29:0]        m6;
        logic signed [54:0] pm;
        logic signed [54:0] q;
        logic [47:0]        cb;
        logic signed [54:0] pu;
        for (int i = 0; i < 3; i++) begin
            sq           = 48'(fr2_reg[i]) * 48'(fr2_reg[i]);
            tt_next[i]   = sq[47:24];
            m6           = 30'(fr2_reg[i]) * 30'd6 - 30'd251658240;
            pm           = $signed({1'b0, fr2_reg[i]}) * $signed(m6);
            q            = (pm >>> WORK_BITS) + 55'sd167772160;
            in_next[i]   = q[29:0];
            cb           = 48'(tt3_reg[i]) * 48'(fr3_reg[i]);
            cube_next[i] = cb[47:24];
            pu           = $signed({1'b0, cube4_reg[i]}) * in4_reg[i];
            u_next[i]    = pu[49:24];
        end
        for (int k = 0; k < 4; k++) begin
            d_next[k]   = gdot(c_rd0[k][3:0], corner(fr4_reg[0], (k & 1) != 0),
                               corner(fr4_reg[1], (k & 2) != 0), corner(fr4_reg[2], 1'b0));
            d_next[k+4] = gdot(c_rd1[k][3:0], corner(fr4_reg[0], (k & 1) != 0),
                               corner(fr4_reg[1], (k & 2) != 0), corner(fr4_reg[2], 1'b1));
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            {pt1_reg, pt2_reg, pt3_reg, pt4_reg, pt5_reg}   <= '0;
            {pt6_reg, pt7_reg, pt8_reg, pt9_reg, pt10_reg}  <= '0;
            {ld1_reg, ld2_reg, ld3_reg}                     <= '0;
        end else if (adv) begin
            pt1_reg  <= s_fire && s_tuser == KIND_POINT && full;
            ld1_reg  <= s_fire && s_tuser == KIND_LOAD;
            pt2_reg  <= pt1_reg;
            ld2_reg  <= ld1_reg;
            pt3_reg  <= pt2_reg;
            ld3_reg  <= ld2_reg;
            pt4_reg  <= pt3_reg;
            pt5_reg  <= pt4_reg;
            pt6_reg  <= pt5_reg;
            pt7_reg  <= pt6_reg;
            pt8_reg  <= pt7_reg;
            pt9_reg  <= pt8_reg;
            pt10_reg <= pt9_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            idx1_reg  <= in_idx;
            val1_reg  <= in_val;
            last1_reg <= s_tlast;

            idx2_reg  <= idx1_reg;
            val2_reg  <= val1_reg;
            last2_reg <= last1_reg;
            cy2_reg   <= cell_idx[1][7:0];
            cz2_reg   <= cell_idx[2][7:0];

            idx3_reg  <= idx2_reg;
            val3_reg  <= val2_reg;
            last3_reg <= last2_reg;
            cz3_reg   <= cz2_reg;

            last4_reg <= last3_reg;
            last5_reg <= last4_reg;
            for (int i = 0; i < 3; i++) begin
                fr2_reg[i]   <= fr1[i];
                fr3_reg[i]   <= fr2_reg[i];
                tt3_reg[i]   <= tt_next[i];
                in3_reg[i]   <= in_next[i];
                fr4_reg[i]   <= fr3_reg[i];
                cube4_reg[i] <= cube_next[i];
                in4_reg[i]   <= in3_reg[i];
                u5_reg[i]    <= u_next[i];
            end
            for (int k = 0; k < 8; k++) begin
                d5_reg[k] <= d_next[k];
            end

            last6_reg <= last5_reg;
            uy6_reg   <= u5_reg[1];
            uz6_reg   <= u5_reg[2];
            for (int k = 0; k < 4; k++) begin
                a6_reg[k] <= lerp_t'(d5_reg[2*k]);
                p6_reg[k] <= lerp_prod(u5_reg[0], lerp_t'(d5_reg[2*k]),
                                       lerp_t'(d5_reg[2*k+1]));
            end

            last7_reg <= last6_reg;
            uy7_reg   <= uy6_reg;
            uz7_reg   <= uz6_reg;
            for (int k = 0; k < 4; k++) begin
                lx7_reg[k] <= lerp_fin(a6_reg[k], p6_reg[k]);
            end

            last8_reg <= last7_reg;
            uz8_reg   <= uz7_reg;
            for (int k = 0; k < 2; k++) begin
                a8_reg[k] <= lx7_reg[2*k];
                p8_reg[k] <= lerp_prod(uy7_reg, lx7_reg[2*k], lx7_reg[2*k+1]);
            end

            last9_reg <= last8_reg;
            uz9_reg   <= uz8_reg;
            for (int k = 0; k < 2; k++) begin
                ly9_reg[k] <= lerp_fin(a8_reg[k], p8_reg[k]);
            end

            last10_reg <= last9_reg;
            a10_reg    <= ly9_reg[0];
            p10_reg    <= lerp_prod(uz9_reg, ly9_reg[0], ly9_reg[1]);
        end
    end

    // final blend and clamp
    lerp_t                 v_full;
    logic signed [25:0]    v_sat;
    logic [26:0]           skid_out;

    always_comb begin
        v_full = lerp_fin(a10_reg, p10_reg);
        if (v_full > 30'sd33554431) begin
            v_sat = 26'sd33554431;
        end else if (v_full < -30'sd33554432) begin
            v_sat = -26'sd33554432;
        end else begin
            v_sat = v_full[25:0];
        end
    end

    pn3_skid #(.W(27)) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pt10_reg),
        .in_ready  (skid_ready),
        .in_data   ({last10_reg, v_sat}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (skid_out)
    );

    assign m_tdata = {6'b0, skid_out[25:0]};
    assign m_tlast = skid_out[26];

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> count_reg[PERM_AW-1:0] == '0)
        else $error("written count above table depth");

    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(written_reg) == int'(count_reg))
        else $error("written count disagrees with entry flags");

    a_drop_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !full) |=> !pt1_reg)
        else $error("point admitted before table complete");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!adv && pt10_reg) |=> pt10_reg && $stable(v_sat))
        else $error("last stage changed during stall");

    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ld1_reg && pt1_reg))
        else $error("stage holds load and point at once");
`endif

endmodule
